FILE: hdl/rihv_pkg.sv
`default_nettype none

package rihv_pkg;

  localparam int MAX_SIZE_CODE = 8;
  localparam int POS_W = 16 + MAX_SIZE_CODE;
  localparam int CODE_W = 4;
  localparam int MISS_W = 6;
  localparam int IMG_W = 24;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int LOGO_LEN = 48;
  localparam int LOGO_IDX_W = 6;

  localparam logic [POS_W-1:0] BANK_BYTES = POS_W'(32'h8000);
  localparam logic [POS_W-1:0] MAX_BYTES = {1'b1, {(15 + MAX_SIZE_CODE){1'b0}}};
  localparam logic [POS_W-1:0] LOGO_START = POS_W'(16'h0104);
  localparam logic [POS_W-1:0] LOGO_END = POS_W'(16'h0134);
  localparam logic [POS_W-1:0] HDR_START = POS_W'(16'h0134);
  localparam logic [POS_W-1:0] TYPE_ADDR = POS_W'(16'h0147);
  localparam logic [POS_W-1:0] SIZE_ADDR = POS_W'(16'h0148);
  localparam logic [POS_W-1:0] HCHK_ADDR = POS_W'(16'h014D);
  localparam logic [POS_W-1:0] GCHK_HI_ADDR = POS_W'(16'h014E);
  localparam logic [POS_W-1:0] GCHK_LO_ADDR = POS_W'(16'h014F);
  localparam logic [7:0] HDR_SEED = 8'hE7;

  localparam logic [7:0] LOGO_REF [0:LOGO_LEN-1] = '{
    8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B, 8'h03, 8'h73, 8'h00, 8'h83,
    8'h00, 8'h0C, 8'h00, 8'h0D, 8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
    8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99, 8'hBB, 8'hBB, 8'h67, 8'h63,
    8'h6E, 8'h0E, 8'hEC, 8'hCC, 8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
  };

  // Number of nonzero reference bytes from each logo index to the end.
  localparam logic [MISS_W-1:0] LOGO_TAIL [0:LOGO_LEN-1] = '{
    6'd42, 6'd41, 6'd40, 6'd39, 6'd38, 6'd37, 6'd36, 6'd36, 6'd35, 6'd34, 6'd33, 6'd33,
    6'd32, 6'd32, 6'd31, 6'd31, 6'd30, 6'd30, 6'd29, 6'd28, 6'd27, 6'd26, 6'd25, 6'd25,
    6'd24, 6'd23, 6'd22, 6'd21, 6'd20, 6'd19, 6'd18, 6'd17, 6'd16, 6'd15, 6'd14, 6'd13,
    6'd12, 6'd11, 6'd10, 6'd9,  6'd8,  6'd7,  6'd6,  6'd5,  6'd4,  6'd3,  6'd2,  6'd1
  };

  typedef enum logic [2:0] {
    K_PLAIN,
    K_HEADER,
    K_HCHK,
    K_GHI,
    K_GLO,
    K_SKIP
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t kind;
    logic cap_type;
    logic cap_size;
    logic logo_miss;
    logic last;
    logic [POS_W-1:0] count;
    logic [CODE_W-1:0] size_code;
    logic [MISS_W-1:0] logo_tail;
  } rec_t;

  typedef struct packed {
    logic [15:0] global_sum;
    logic [7:0] header_sum;
    logic global_ok;
    logic header_ok;
    logic [MISS_W-1:0] logo_mismatches;
    logic [CODE_W-1:0] size_code;
    logic size_ok;
    logic type_fix_needed;
    logic [IMG_W-1:0] image_bytes;
    logic too_large;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/rihv_front.sv
`default_nettype none

module rihv_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_data,
  input  wire logic              in_last,
  input  wire logic              q_ready,
  output logic                   in_ready,
  output logic                   push,
  output rihv_pkg::rec_t         push_rec
);

  logic [rihv_pkg::POS_W-1:0] position_r;
  logic [rihv_pkg::POS_W-1:0] position_nxt;
  logic take;
  logic in_logo;
  logic [rihv_pkg::LOGO_IDX_W-1:0] logo_idx;
  logic [rihv_pkg::LOGO_IDX_W-1:0] tail_idx;
  logic [rihv_pkg::POS_W-1:0] cnt;
  logic [rihv_pkg::CODE_W-1:0] code;

  assign in_ready = q_ready;
  assign push = in_valid && q_ready;

  always_comb begin
    take = position_r < rihv_pkg::MAX_BYTES;
    in_logo = (position_r >= rihv_pkg::LOGO_START) && (position_r < rihv_pkg::LOGO_END);
    logo_idx = rihv_pkg::LOGO_IDX_W'(position_r - rihv_pkg::LOGO_START);
    cnt = take ? position_r + rihv_pkg::POS_W'(1) : position_r;

    code = '0;
    for (int k = 0; k < rihv_pkg::MAX_SIZE_CODE; k++) begin
      if (cnt > (rihv_pkg::BANK_BYTES << k)) begin
        code = code + rihv_pkg::CODE_W'(1);
      end
    end

    tail_idx = '0;
    if (cnt > rihv_pkg::LOGO_START) begin
      tail_idx = rihv_pkg::LOGO_IDX_W'(cnt - rihv_pkg::LOGO_START);
    end

    push_rec.data = in_data;
    push_rec.last = in_last;
    push_rec.count = cnt;
    push_rec.size_code = code;
    push_rec.logo_tail = (cnt >= rihv_pkg::LOGO_END) ? '0 : rihv_pkg::LOGO_TAIL[tail_idx];
    push_rec.cap_type = take && (position_r == rihv_pkg::TYPE_ADDR);
    push_rec.cap_size = take && (position_r == rihv_pkg::SIZE_ADDR);
    push_rec.logo_miss = take && in_logo && (in_data != rihv_pkg::LOGO_REF[logo_idx]);

    if (!take) begin
      push_rec.kind = rihv_pkg::K_SKIP;
    end else if (position_r == rihv_pkg::HCHK_ADDR) begin
      push_rec.kind = rihv_pkg::K_HCHK;
    end else if (position_r == rihv_pkg::GCHK_HI_ADDR) begin
      push_rec.kind = rihv_pkg::K_GHI;
    end else if (position_r == rihv_pkg::GCHK_LO_ADDR) begin
      push_rec.kind = rihv_pkg::K_GLO;
    end else if (position_r >= rihv_pkg::HDR_START && position_r < rihv_pkg::HCHK_ADDR) begin
      push_rec.kind = rihv_pkg::K_HEADER;
    end else begin
      push_rec.kind = rihv_pkg::K_PLAIN;
    end

    position_nxt = position_r;
    if (push) begin
      position_nxt = in_last ? '0 : cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
    end else begin
      position_r <= position_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rihv_queue.sv
`default_nettype none

module rihv_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rihv_pkg::rec_t    push_rec,
  output logic                   q_ready,
  input  wire logic              pop,
  output logic                   head_valid,
  output rihv_pkg::rec_t         head_rec
);

  rihv_pkg::rec_t mem [0:rihv_pkg::Q_DEPTH-1];
  logic [rihv_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [rihv_pkg::Q_PTR_W-1:0] wr_ptr_nxt;
  logic [rihv_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [rihv_pkg::Q_PTR_W-1:0] rd_ptr_nxt;
  logic [rihv_pkg::Q_CNT_W-1:0] count_r;
  logic [rihv_pkg::Q_CNT_W-1:0] count_nxt;

  assign q_ready = count_r != rihv_pkg::Q_CNT_W'(rihv_pkg::Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head_rec = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + rihv_pkg::Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + rihv_pkg::Q_PTR_W'(1) : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + rihv_pkg::Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - rihv_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rihv_back.sv
`default_nettype none

module rihv_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire rihv_pkg::rec_t    head_rec,
  output logic                   pop,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output rihv_pkg::res_t         out_res
);

  logic [15:0] global_r;
  logic [15:0] global_nxt;
  logic [7:0] header_r;
  logic [7:0] header_nxt;
  logic [15:0] sglobal_r;
  logic [15:0] sglobal_nxt;
  logic [7:0] sheader_r;
  logic [7:0] sheader_nxt;
  logic [7:0] ssize_r;
  logic [7:0] ssize_nxt;
  logic [7:0] stype_r;
  logic [7:0] stype_nxt;
  logic [rihv_pkg::MISS_W-1:0] miss_r;
  logic [rihv_pkg::MISS_W-1:0] miss_nxt;
  logic over_r;
  logic over_nxt;

  logic snap_v_r;
  logic snap_v_nxt;
  logic [15:0] snap_global_r;
  logic [7:0] snap_header_r;
  logic [15:0] snap_sglobal_r;
  logic [7:0] snap_sheader_r;
  logic [7:0] snap_ssize_r;
  logic [7:0] snap_stype_r;
  logic [rihv_pkg::MISS_W-1:0] snap_miss_r;
  logic [rihv_pkg::POS_W-1:0] snap_count_r;
  logic [rihv_pkg::CODE_W-1:0] snap_code_r;
  logic snap_over_r;

  logic out_v_r;
  logic out_v_nxt;
  rihv_pkg::res_t out_r;
  rihv_pkg::res_t out_nxt;
  logic out_ld;
  logic snap_free;
  logic take_last;

  assign out_ld = snap_v_r && (!out_v_r || out_ready);
  assign snap_free = !snap_v_r || out_ld;
  assign pop = head_valid && (!head_rec.last || snap_free);
  assign take_last = pop && head_rec.last;
  assign out_valid = out_v_r;
  assign out_res = out_r;

  always_comb begin
    global_nxt = global_r;
    header_nxt = header_r;
    sglobal_nxt = sglobal_r;
    sheader_nxt = sheader_r;
    over_nxt = over_r;
    case (head_rec.kind)
      rihv_pkg::K_PLAIN: begin
        global_nxt = global_r + {8'h00, head_rec.data};
      end
      rihv_pkg::K_HEADER: begin
        global_nxt = global_r + {8'h00, head_rec.data};
        header_nxt = header_r + head_rec.data;
      end
      rihv_pkg::K_HCHK: begin
        sheader_nxt = head_rec.data;
      end
      rihv_pkg::K_GHI: begin
        sglobal_nxt = {head_rec.data, sglobal_r[7:0]};
      end
      rihv_pkg::K_GLO: begin
        sglobal_nxt = {sglobal_r[15:8], head_rec.data};
      end
      rihv_pkg::K_SKIP: begin
        over_nxt = 1'b1;
      end
      default: begin
        over_nxt = over_r;
      end
    endcase
    ssize_nxt = head_rec.cap_size ? head_rec.data : ssize_r;
    stype_nxt = head_rec.cap_type ? head_rec.data : stype_r;
    miss_nxt = miss_r + rihv_pkg::MISS_W'(head_rec.logo_miss);
  end

  always_comb begin
    out_nxt.header_sum = rihv_pkg::HDR_SEED - snap_header_r;
    out_nxt.global_sum = snap_global_r + {8'h00, out_nxt.header_sum};
    out_nxt.global_ok = snap_sglobal_r == out_nxt.global_sum;
    out_nxt.header_ok = snap_sheader_r == out_nxt.header_sum;
    out_nxt.logo_mismatches = snap_miss_r;
    out_nxt.size_code = snap_code_r;
    out_nxt.size_ok = snap_ssize_r == 8'(snap_code_r);
    out_nxt.type_fix_needed = (snap_count_r > rihv_pkg::BANK_BYTES) && (snap_stype_r == 8'h00);
    out_nxt.image_bytes = rihv_pkg::IMG_W'(snap_count_r);
    out_nxt.too_large = snap_over_r;

    snap_v_nxt = take_last ? 1'b1 : (out_ld ? 1'b0 : snap_v_r);
    out_v_nxt = out_ld ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_r <= '0;
      header_r <= '0;
      sglobal_r <= '0;
      sheader_r <= '0;
      ssize_r <= '0;
      stype_r <= '0;
      miss_r <= '0;
      over_r <= 1'b0;
      snap_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
      out_v_r <= out_v_nxt;
      if (take_last) begin
        global_r <= '0;
        header_r <= '0;
        sglobal_r <= '0;
        sheader_r <= '0;
        ssize_r <= '0;
        stype_r <= '0;
        miss_r <= '0;
        over_r <= 1'b0;
      end else if (pop) begin
        global_r <= global_nxt;
        header_r <= header_nxt;
        sglobal_r <= sglobal_nxt;
        sheader_r <= sheader_nxt;
        ssize_r <= ssize_nxt;
        stype_r <= stype_nxt;
        miss_r <= miss_nxt;
        over_r <= over_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      snap_global_r <= global_nxt;
      snap_header_r <= header_nxt;
      snap_sglobal_r <= sglobal_nxt;
      snap_sheader_r <= sheader_nxt;
      snap_ssize_r <= ssize_nxt;
      snap_stype_r <= stype_nxt;
      snap_miss_r <= miss_nxt + head_rec.logo_tail;
      snap_count_r <= head_rec.count;
      snap_code_r <= head_rec.size_code;
      snap_over_r <= over_nxt;
    end
    if (out_ld) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_snap_holds: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && !out_ld |=> snap_v_r)
    else $error("pending result lost before reaching the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(take_last && snap_v_r && !out_ld))
    else $error("last item taken while the result snapshot is still occupied");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take_last |=> (global_r == 16'h0000) && (miss_r == '0) && !over_r)
    else $error("accumulators not cleared after the last item");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> out_v_r)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

FILE: hdl/rom_image_header_validator_unit.sv
`default_nettype none

// Validates a cartridge ROM image streamed one byte per item in address order and
// reports, after the item marked by in_tlast, the header and global checksums, the
// logo mismatch count, the size code and related flags; all state then returns to
// reset so the next item starts a new image at address zero. The unit sustains one
// item per clock while the queue has room: the front classifies each byte by
// address, a four-entry queue decouples it from the back end, which accumulates one
// item per cycle unless a last item waits for the snapshot stage to free. A result
// goes from the queue through a snapshot stage and an output register to the output.
module rom_image_header_validator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte[7:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // global_sum[15:0], header_sum[23:16], global_ok[24], header_ok[25],
  // logo_mismatches[31:26], size_code[35:32], size_ok[36], type_fix_needed[37],
  // image_bytes[61:38], too_large[62], zero[63]
  output logic [63:0]      out_tdata
);

  logic push;
  logic pop;
  logic q_ready;
  logic head_valid;
  rihv_pkg::rec_t push_rec;
  rihv_pkg::rec_t head_rec;
  rihv_pkg::res_t res;

  rihv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .q_ready  (q_ready),
    .in_ready (in_tready),
    .push     (push),
    .push_rec (push_rec)
  );

  rihv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  rihv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (res)
  );

  assign out_tdata = {1'b0, res.too_large, res.image_bytes, res.type_fix_needed,
                      res.size_ok, res.size_code, res.logo_mismatches, res.header_ok,
                      res.global_ok, res.header_sum, res.global_sum};

endmodule

`default_nettype wire

FILE: tb/rom_image_header_validator_unit_test.sv
`timescale 1ns / 100ps

module rom_image_header_validator_unit_test;

  localparam int unsigned BANK = 32'h8000;
  localparam int unsigned MAX_IMAGE = BANK << rihv_pkg::MAX_SIZE_CODE;
  localparam int unsigned LOGO_BASE = 32'h104;
  localparam int unsigned LOGO_SPAN = 48;
  localparam int unsigned HDR_BASE = 32'h134;
  localparam int unsigned TYPE_POS = 32'h147;
  localparam int unsigned SIZE_POS = 32'h148;
  localparam int unsigned HCHK_POS = 32'h14D;
  localparam int unsigned GHI_POS = 32'h14E;
  localparam int unsigned GLO_POS = 32'h14F;
  localparam int unsigned FULL_HEADER = 32'h150;
  localparam logic [7:0] HDR_SEED = 8'hE7;

  localparam logic [7:0] LOGO_BYTES [LOGO_SPAN] = '{
    8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B, 8'h03, 8'h73, 8'h00, 8'h83,
    8'h00, 8'h0C, 8'h00, 8'h0D, 8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
    8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99, 8'hBB, 8'hBB, 8'h67, 8'h63,
    8'h6E, 8'h0E, 8'hEC, 8'hCC, 8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
  };

  typedef struct packed {
    logic        pad;
    logic        too_large;
    logic [23:0] image_bytes;
    logic        type_fix_needed;
    logic        size_ok;
    logic [3:0]  size_code;
    logic [5:0]  logo_mismatches;
    logic        header_ok;
    logic        global_ok;
    logic [7:0]  header_sum;
    logic [15:0] global_sum;
  } summary_t;

  class checksum_scoreboard;
    summary_t expected_summaries[$];
    int unsigned mismatches;
    int unsigned position;
    logic [15:0] global_acc;
    logic [7:0] header_acc;
    logic [15:0] stored_global;
    logic [7:0] stored_header;
    logic [7:0] stored_size;
    logic [7:0] stored_type;
    logic [5:0] logo_misses;
    logic overflow;

    function new();
      mismatches = 0;
      clear_image();
    endfunction

    function void clear_image();
      position = 0;
      global_acc = '0;
      header_acc = '0;
      stored_global = '0;
      stored_header = '0;
      stored_size = '0;
      stored_type = '0;
      logo_misses = '0;
      overflow = 1'b0;
    endfunction

    function void absorb_byte(logic [7:0] b, logic last);
      summary_t s;
      int unsigned code;
      int unsigned idx;
      int unsigned tail;
      if (position < MAX_IMAGE) begin
        if (position >= LOGO_BASE && position < LOGO_BASE + LOGO_SPAN &&
            b != LOGO_BYTES[position - LOGO_BASE])
          logo_misses++;
        if (position == TYPE_POS) stored_type = b;
        if (position == SIZE_POS) stored_size = b;
        if (position == HCHK_POS) begin
          stored_header = b;
        end else if (position == GHI_POS) begin
          stored_global[15:8] = b;
        end else if (position == GLO_POS) begin
          stored_global[7:0] = b;
        end else begin
          global_acc += 16'(b);
          if (position >= HDR_BASE && position < HCHK_POS) header_acc += b;
        end
        position++;
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;
      // Logo entries beyond the end of a short image compare as zero bytes.
      tail = 0;
      idx = (position > LOGO_BASE) ? position - LOGO_BASE : 0;
      while (idx < LOGO_SPAN) begin
        if (LOGO_BYTES[idx] != 8'h00) tail++;
        idx++;
      end
      code = 0;
      while (code < rihv_pkg::MAX_SIZE_CODE && position > (BANK << code)) code++;
      s.pad = 1'b0;
      s.header_sum = HDR_SEED - header_acc;
      s.global_sum = global_acc + 16'(s.header_sum);
      s.global_ok = (stored_global == s.global_sum);
      s.header_ok = (stored_header == s.header_sum);
      s.logo_mismatches = 6'(logo_misses + tail);
      s.size_code = 4'(code);
      s.size_ok = (32'(stored_size) == code);
      s.type_fix_needed = (position > BANK) && (stored_type == 8'h00);
      s.image_bytes = 24'(position);
      s.too_large = overflow;
      expected_summaries.push_back(s);
      clear_image();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
      mismatches++;
    endtask

    task compare_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_summary(logic [63:0] raw);
      summary_t got;
      summary_t want;
      if (expected_summaries.size() == 0) begin
        report_mismatch("result with no image pending", raw[31:0], 32'h0);
        return;
      end
      got = raw;
      want = expected_summaries.pop_front();
      compare_field("global_sum", 32'(got.global_sum), 32'(want.global_sum));
      compare_field("header_sum", 32'(got.header_sum), 32'(want.header_sum));
      compare_field("global_ok", 32'(got.global_ok), 32'(want.global_ok));
      compare_field("header_ok", 32'(got.header_ok), 32'(want.header_ok));
      compare_field("logo_mismatches", 32'(got.logo_mismatches),
                    32'(want.logo_mismatches));
      compare_field("size_code", 32'(got.size_code), 32'(want.size_code));
      compare_field("size_ok", 32'(got.size_ok), 32'(want.size_ok));
      compare_field("type_fix_needed", 32'(got.type_fix_needed),
                    32'(want.type_fix_needed));
      compare_field("image_bytes", 32'(got.image_bytes), 32'(want.image_bytes));
      compare_field("too_large", 32'(got.too_large), 32'(want.too_large));
      compare_field("pad", 32'(got.pad), 32'(want.pad));
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;

  checksum_scoreboard sb = new();
  logic [7:0] rom_q[$];
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 47;
  int unsigned items_sent = 0;

  rom_image_header_validator_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_summary(out_tdata);
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.absorb_byte(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  task send_rom();
    int i;
    for (i = 0; i < rom_q.size(); i++) send_byte(rom_q[i], (i == rom_q.size() - 1));
  endtask

  task wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_summaries.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Builds an image in rom_q. A negative size or type byte leaves that position as filled.
  task make_image(input int unsigned len, input bit noise, input bit logo_ok,
                  input int unsigned logo_errs, input bit fix_hchk, input bit fix_gchk,
                  input int size_b, input int type_b);
    int unsigned i;
    int unsigned span_end;
    logic [7:0] hs;
    logic [15:0] gs;
    rom_q.delete();
    for (i = 0; i < len; i++) rom_q.push_back(noise ? 8'($urandom) : 8'h00);
    if (logo_ok)
      for (i = 0; i < LOGO_SPAN && LOGO_BASE + i < len; i++)
        rom_q[LOGO_BASE + i] = LOGO_BYTES[i];
    span_end = (len < LOGO_BASE + LOGO_SPAN) ? len : LOGO_BASE + LOGO_SPAN;
    for (i = 0; i < logo_errs && len > LOGO_BASE; i++)
      rom_q[$urandom_range(LOGO_BASE, span_end - 1)] ^= 8'($urandom_range(1, 255));
    if (type_b >= 0 && len > TYPE_POS) rom_q[TYPE_POS] = 8'(type_b);
    if (size_b >= 0 && len > SIZE_POS) rom_q[SIZE_POS] = 8'(size_b);
    hs = HDR_SEED;
    gs = '0;
    for (i = 0; i < len; i++) begin
      if (i >= HDR_BASE && i < HCHK_POS) hs -= rom_q[i];
      if (i < HCHK_POS || i > GLO_POS) gs += 16'(rom_q[i]);
    end
    gs += 16'(hs);
    if (fix_hchk && len > HCHK_POS) rom_q[HCHK_POS] = hs;
    if (fix_gchk && len > GLO_POS) begin
      rom_q[GHI_POS] = gs[15:8];
      rom_q[GLO_POS] = gs[7:0];
    end
  endtask

  task random_image(input int unsigned room);
    int unsigned pick;
    int unsigned short_max;
    pick = $urandom_range(0, 99);
    short_max = (room < 40) ? room : 40;
    if (pick < 65 && room >= FULL_HEADER + 8) begin
      make_image(FULL_HEADER + $urandom_range(0, 8), 1'b1, 1'b1,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0,
                 ($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0,
                 ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255));
    end else if (pick < 90 && room >= FULL_HEADER) begin
      make_image($urandom_range(32'h100, FULL_HEADER - 1), 1'b1, 1'b1, 0, 1'b1, 1'b1, -1, -1);
    end else begin
      make_image($urandom_range(1, short_max), 1'b1, 1'b0, 0, 1'b0, 1'b0, -1, -1);
    end
    send_rom();
  endtask

  task random_phase(input int unsigned budget);
    int unsigned start_items;
    start_items = items_sent;
    while (items_sent - start_items < budget) begin
      random_image(budget - (items_sent - start_items));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    make_image(1, 1'b0, 1'b0, 0, 1'b0, 1'b0, -1, -1);
    send_rom();
    rom_q = '{8'hFF};
    send_rom();
    rom_q = '{8'h80};
    send_rom();
    rom_q = '{8'h7F};
    send_rom();
    wait_drained();

    random_phase(350);
    wait_drained();
    send_idle_pct = 47;
    recv_idle_pct = 17;
    random_phase(350);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(350);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_summaries.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
